### hdl/tga_rle_pkg.sv
package tga_rle_pkg;

	// Configuration register indexes on the write port.
	localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd0;
	localparam logic [1:0] REG_COMPRESSED_MODE = 2'd1;
	localparam logic [1:0] REG_TOTAL_PIXELS    = 2'd2;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_INDEX_W = 2;

	// Register values after reset.
	localparam logic [2:0]  RST_BYTES_PER_PIXEL = 3'd4;
	localparam logic        RST_COMPRESSED_MODE = 1'b1;
	localparam logic [31:0] RST_TOTAL_PIXELS    = 32'd1;

	// Packet header decoding.
	localparam logic [7:0] RUN_HEADER_BASE = 8'd127;
	localparam logic [7:0] OPAQUE_ALPHA    = 8'd255;

	typedef struct packed {
		logic [2:0]  bytes_per_pixel;
		logic        compressed_mode;
		logic [31:0] total_pixels;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] repeat_count;
		logic       image_complete;
		logic       truncated;
	} result_t;

endpackage

### hdl/tga_rle_pixel_decoder_core.sv
// TGA run-length pixel decoder for 24 and 32 bit images. Payload bytes enter one per
// transaction on the input channel and RGBA pixels leave on the output channel; a run
// packet leaves as a single transaction whose repeat_count gives the number of copies,
// clamped so that output never passes total_pixels. The block takes one byte per cycle
// unless a stalled output has filled both registers. A byte that completes a pixel
// reaches the output thus: the byte is held in an input register, decoded by the packet
// and pixel state logic, and the result sits in an output register until it is taken. A
// stalled output holds back the input only once both registers are full. After the image
// is complete, or after a byte marked end_of_stream, every further byte is dropped until
// reset. A stream that ends inside a header or an unfinished pixel gives a bare result
// with truncated set and repeat_count 0. Configuration writes go to bytes_per_pixel
// (index 0), compressed_mode (index 1) and total_pixels (index 2) and must only be made
// while no transaction is in flight.
module tga_rle_pixel_decoder_core (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_wr_en,
	input  logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_wdata,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          data_byte,
	input  logic                                end_of_stream,

	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue,
	output logic [7:0]                          alpha,
	output logic [7:0]                          repeat_count,
	output logic                                image_complete,
	output logic                                truncated
);

	tga_rle_pkg::cfg_t    cfg_q;
	tga_rle_pkg::result_t step_res;
	tga_rle_pkg::result_t res_s2;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eos_s1;
	logic       valid_s2;
	logic       step_res_valid;
	logic       out_free;
	logic       fire;

	// Configuration registers; a write to an unused index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bytes_per_pixel <= tga_rle_pkg::RST_BYTES_PER_PIXEL;
			cfg_q.compressed_mode <= tga_rle_pkg::RST_COMPRESSED_MODE;
			cfg_q.total_pixels    <= tga_rle_pkg::RST_TOTAL_PIXELS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tga_rle_pkg::REG_BYTES_PER_PIXEL: cfg_q.bytes_per_pixel <= cfg_wdata[2:0];
				tga_rle_pkg::REG_COMPRESSED_MODE: cfg_q.compressed_mode <= cfg_wdata[0];
				tga_rle_pkg::REG_TOTAL_PIXELS:    cfg_q.total_pixels    <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// The held byte is decoded whenever the output register can take whatever it yields.
	assign out_free = !valid_s2 || out_ready;
	assign fire     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			eos_s1  <= end_of_stream;
		end
	end

	tga_rle_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.fire          (fire),
		.data_byte     (data_s1),
		.end_of_stream (eos_s1),
		.res_valid     (step_res_valid),
		.res           (step_res)
	);

	// Output register: loaded only when a decoded byte produces a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= fire && step_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && step_res_valid) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid      = valid_s2;
	assign red            = res_s2.red;
	assign green          = res_s2.green;
	assign blue           = res_s2.blue;
	assign alpha          = res_s2.alpha;
	assign repeat_count   = res_s2.repeat_count;
	assign image_complete = res_s2.image_complete;
	assign truncated      = res_s2.truncated;

endmodule

### hdl/tga_rle_step.sv
module tga_rle_step (
	input  logic                clk,
	input  logic                arst_n,
	input  tga_rle_pkg::cfg_t   cfg,
	input  logic                fire,
	input  logic [7:0]          data_byte,
	input  logic                end_of_stream,
	output logic                res_valid,
	output tga_rle_pkg::result_t res
);

	logic        header_expected_q;
	logic        packet_is_run_q;
	logic [7:0]  pixels_left_q;
	logic [1:0]  byte_in_pixel_q;
	logic [23:0] gathered_q;
	logic [31:0] pixels_emitted_q;
	logic        finished_q;

	logic        header_expected_d;
	logic        packet_is_run_d;
	logic [7:0]  pixels_left_d;
	logic [1:0]  byte_in_pixel_d;
	logic [23:0] gathered_d;
	logic [31:0] pixels_emitted_d;
	logic        finished_d;

	logic        size4;
	logic        pixel_done;
	logic [7:0]  rep_raw;
	logic [7:0]  rep;
	logic [31:0] remaining;
	logic        trunc;
	logic        done;

	assign size4 = cfg.bytes_per_pixel[2];
	assign remaining = cfg.total_pixels - pixels_emitted_q;
	// A pixel is complete once its byte position reaches the last byte of the pixel size.
	assign pixel_done = size4 ? (byte_in_pixel_q == 2'd3) : (byte_in_pixel_q >= 2'd2);

	always_comb begin
		header_expected_d = header_expected_q;
		packet_is_run_d   = packet_is_run_q;
		pixels_left_d     = pixels_left_q;
		byte_in_pixel_d   = byte_in_pixel_q;
		gathered_d        = gathered_q;
		pixels_emitted_d  = pixels_emitted_q;
		finished_d        = finished_q;
		res_valid         = 1'b0;
		res               = '0;
		rep_raw           = 8'd1;
		rep               = 8'd1;
		trunc             = 1'b0;
		done              = 1'b0;

		if (finished_q) begin
			// Everything after the end of the image is dropped.
		end else if (pixels_emitted_q >= cfg.total_pixels) begin
			finished_d = 1'b1;
		end else if (cfg.compressed_mode && header_expected_q) begin
			packet_is_run_d   = data_byte[7];
			pixels_left_d     = data_byte[7] ? (data_byte - tga_rle_pkg::RUN_HEADER_BASE)
			                                 : (data_byte + 8'd1);
			header_expected_d = 1'b0;
			byte_in_pixel_d   = 2'd0;
			if (end_of_stream) begin
				finished_d    = 1'b1;
				res_valid     = 1'b1;
				res.truncated = 1'b1;
			end
		end else begin
			case (byte_in_pixel_q)
				2'd0: gathered_d[7:0]   = data_byte;
				2'd1: gathered_d[15:8]  = data_byte;
				2'd2: gathered_d[23:16] = data_byte;
				default: ;
			endcase

			if (!pixel_done) begin
				byte_in_pixel_d = byte_in_pixel_q + 2'd1;
				if (end_of_stream) begin
					finished_d    = 1'b1;
					res_valid     = 1'b1;
					res.truncated = 1'b1;
				end
			end else begin
				byte_in_pixel_d = 2'd0;
				if (cfg.compressed_mode && packet_is_run_q) begin
					rep_raw           = (pixels_left_q == 8'd0) ? 8'd1 : pixels_left_q;
					pixels_left_d     = 8'd0;
					header_expected_d = 1'b1;
				end else if (cfg.compressed_mode) begin
					if (pixels_left_q > 8'd1) begin
						pixels_left_d = pixels_left_q - 8'd1;
						trunc         = end_of_stream;
					end else begin
						pixels_left_d     = 8'd0;
						header_expected_d = 1'b1;
					end
				end

				// Clamp to the pixels still missing; the image is complete exactly when
				// the clamped count equals what was missing.
				rep  = ({24'd0, rep_raw} > remaining) ? remaining[7:0] : rep_raw;
				done = ({24'd0, rep} == remaining);
				pixels_emitted_d = pixels_emitted_q + {24'd0, rep};
				if (done || end_of_stream) begin
					finished_d = 1'b1;
				end

				res_valid          = 1'b1;
				res.red            = gathered_d[23:16];
				res.green          = gathered_d[15:8];
				res.blue           = gathered_d[7:0];
				res.alpha          = (size4 && byte_in_pixel_q == 2'd3) ? data_byte
				                                                         : tga_rle_pkg::OPAQUE_ALPHA;
				res.repeat_count   = rep;
				res.image_complete = done;
				res.truncated      = trunc && !done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_expected_q <= 1'b1;
			packet_is_run_q   <= 1'b0;
			pixels_left_q     <= 8'd0;
			byte_in_pixel_q   <= 2'd0;
			gathered_q        <= 24'd0;
			pixels_emitted_q  <= 32'd0;
			finished_q        <= 1'b0;
		end else if (fire) begin
			header_expected_q <= header_expected_d;
			packet_is_run_q   <= packet_is_run_d;
			pixels_left_q     <= pixels_left_d;
			byte_in_pixel_q   <= byte_in_pixel_d;
			gathered_q        <= gathered_d;
			pixels_emitted_q  <= pixels_emitted_d;
			finished_q        <= finished_d;
		end
	end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

// Testbench for the TGA run-length pixel decoder core.
//
// Payload bytes are pushed through the input channel by plain tasks. Every byte that the
// core accepts is handed to a scoreboard object, which keeps its own copy of the register
// settings and of the packet and pixel state and queues the pixel that the byte should
// produce, if any. A monitor takes each output transaction and compares it field by field
// with the oldest queued pixel.
//
// The core stops for good after its first end_of_stream byte or after the pixel total is
// reached, and reset is applied only once. The bulk of the run therefore keeps the total
// far out of reach and never marks a byte as the last. A single randomly chosen ending
// closes the stream, followed by a few bytes that the core has to drop.
module tb;

	// Cycles without any accepted transaction before the run is declared hung.
	localparam int unsigned HANG_LIMIT = 5000;
	// Extra cycles granted after the last expected pixel, covering the two-stage pipeline.
	localparam int unsigned DRAIN_CYCLES = 8;
	// Bytes per randomized phase.
	localparam int unsigned PHASE_BYTES = 130;
	localparam int unsigned PHASE_COUNT = 12;

	// The different ways the stream is brought to its end.
	typedef enum int unsigned {
		END_HEADER_EOS,
		END_PIXEL_EOS,
		END_RAW_EOS,
		END_BOUNDARY_EOS,
		END_RUN_CLAMP,
		END_TOTAL_LOWERED
	} ending_t;

	// Scoreboard: predicts the pixel stream from the accepted bytes and checks the core's
	// output transactions against it in order.
	class pixel_scoreboard_t;
		logic [2:0]  pix_bytes_cfg;
		logic        rle_mode_cfg;
		logic [31:0] pixel_total_cfg;

		bit          want_header;
		bit          in_run;
		logic [7:0]  left_in_packet;
		logic [1:0]  byte_pos;
		logic [23:0] bgr_bytes;
		logic [31:0] pixels_out;
		bit          stopped;

		tga_rle_pkg::result_t expected_pixels[$];
		int unsigned errors;

		function new();
			pix_bytes_cfg   = tga_rle_pkg::RST_BYTES_PER_PIXEL;
			rle_mode_cfg    = tga_rle_pkg::RST_COMPRESSED_MODE;
			pixel_total_cfg = tga_rle_pkg::RST_TOTAL_PIXELS;
			want_header     = 1'b1;
			in_run          = 1'b0;
			left_in_packet  = '0;
			byte_pos        = '0;
			bgr_bytes       = '0;
			pixels_out      = '0;
			stopped         = 1'b0;
			errors          = 0;
		endfunction

		// Sizes below 4 act as 3 bytes, everything from 4 up acts as 4 bytes.
		function int unsigned pixel_size();
			return (pix_bytes_cfg >= 3'd4) ? 4 : 3;
		endfunction

		function void write_reg(logic [tga_rle_pkg::CFG_INDEX_W-1:0] idx,
			logic [tga_rle_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				tga_rle_pkg::REG_BYTES_PER_PIXEL: pix_bytes_cfg = data[2:0];
				tga_rle_pkg::REG_COMPRESSED_MODE: rle_mode_cfg = data[0];
				tga_rle_pkg::REG_TOTAL_PIXELS: pixel_total_cfg = data;
				default: ;
			endcase
		endfunction

		// A stream that stops inside a header or a pixel yields an all-zero pixel that only
		// carries the truncated flag.
		function void push_truncation();
			tga_rle_pkg::result_t r;
			r = '0;
			r.truncated = 1'b1;
			expected_pixels.push_back(r);
		endfunction

		function void note_byte(logic [7:0] b, logic eos);
			int unsigned sz;
			int unsigned k;
			logic [7:0]  rep;
			logic [31:0] missing;
			bit          trunc;
			tga_rle_pkg::result_t r;
			sz = pixel_size();
			if (stopped)
				return;
			// A total that is already met (zero, or lowered to the output count or below) stops
			// the decoder on the next byte without any output.
			if (pixels_out >= pixel_total_cfg) begin
				stopped = 1'b1;
				return;
			end
			if (rle_mode_cfg && want_header) begin
				in_run = (b > tga_rle_pkg::RUN_HEADER_BASE);
				left_in_packet = in_run ? (b - tga_rle_pkg::RUN_HEADER_BASE) : (b + 8'd1);
				want_header = 1'b0;
				byte_pos = '0;
				if (eos) begin
					stopped = 1'b1;
					push_truncation();
				end
				return;
			end
			k = byte_pos;
			// The fourth byte is alpha and is never stored with the color bytes.
			if (k < 3)
				bgr_bytes[8*k +: 8] = b;
			if (k + 1 < sz) begin
				byte_pos = 2'(k + 1);
				if (eos) begin
					stopped = 1'b1;
					push_truncation();
				end
				return;
			end
			// The byte completes a pixel. A size lowered mid-pixel also ends up here.
			byte_pos = '0;
			r = '0;
			r.red = bgr_bytes[23:16];
			r.green = bgr_bytes[15:8];
			r.blue = bgr_bytes[7:0];
			r.alpha = (sz == 4 && k == 3) ? b : tga_rle_pkg::OPAQUE_ALPHA;
			trunc = 1'b0;
			if (rle_mode_cfg && in_run) begin
				rep = (left_in_packet == 8'd0) ? 8'd1 : left_in_packet;
				left_in_packet = '0;
				want_header = 1'b1;
			end else begin
				rep = 8'd1;
				// Plain pixel mode leaves the packet state alone.
				if (rle_mode_cfg) begin
					if (left_in_packet != 8'd0)
						left_in_packet = left_in_packet - 8'd1;
					if (left_in_packet == 8'd0)
						want_header = 1'b1;
					else if (eos)
						trunc = 1'b1;
				end
			end
			// A run never carries the output past the pixel total.
			missing = pixel_total_cfg - pixels_out;
			if ({24'd0, rep} > missing)
				rep = missing[7:0];
			pixels_out = pixels_out + {24'd0, rep};
			r.repeat_count = rep;
			if (pixels_out == pixel_total_cfg) begin
				r.image_complete = 1'b1;
				stopped = 1'b1;
				trunc = 1'b0;
			end
			if (eos)
				stopped = 1'b1;
			r.truncated = trunc;
			expected_pixels.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
			if (seen !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, seen);
				errors++;
			end
		endfunction

		function void check_pixel(tga_rle_pkg::result_t seen);
			tga_rle_pkg::result_t want;
			if (expected_pixels.size() == 0) begin
				$error("Unexpected pixel transaction: rgba %0d %0d %0d %0d, repeat %0d",
					seen.red, seen.green, seen.blue, seen.alpha, seen.repeat_count);
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("red", want.red, seen.red);
			compare_field("green", want.green, seen.green);
			compare_field("blue", want.blue, seen.blue);
			compare_field("alpha", want.alpha, seen.alpha);
			compare_field("repeat_count", want.repeat_count, seen.repeat_count);
			compare_field("image_complete", 8'(want.image_complete), 8'(seen.image_complete));
			compare_field("truncated", 8'(want.truncated), 8'(seen.truncated));
		endfunction
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;

	logic                                cfg_wr_en = 1'b0;
	logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic [7:0]                          data_byte = '0;
	logic                                end_of_stream = 1'b0;

	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic [7:0]                          red;
	logic [7:0]                          green;
	logic [7:0]                          blue;
	logic [7:0]                          alpha;
	logic [7:0]                          repeat_count;
	logic                                image_complete;
	logic                                truncated;

	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int unsigned                         idle_pct = 0;
	int unsigned                         stall_pct = 0;
	int unsigned                         quiet_cycles = 0;
	int unsigned                         phase_bytes = 0;

	pixel_scoreboard_t                   sb = new();

	tga_rle_pixel_decoder_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_stream  (end_of_stream),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.alpha          (alpha),
		.repeat_count   (repeat_count),
		.image_complete (image_complete),
		.truncated      (truncated)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// The monitor samples the values that were present at the clock edge. All inputs change
	// through nonblocking assignments, so nothing sampled here can depend on process order.
	// The same block also drives out_ready and keeps the hang watchdog.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_pixel({red, green, blue, alpha, repeat_count, image_complete, truncated});
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Offers one byte and returns right after the edge that accepted it. Valid stays high
	// when the next byte follows at once; it is only lowered when an idle gap comes first,
	// so that valid never sees two assignments within one time step.
	task automatic send_byte(input logic [7:0] b, input logic eos);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_byte(b, eos);
		phase_bytes++;
	endtask

	// Brings the core to rest: no byte offered, every predicted pixel received, and a few
	// more cycles so that a byte which completed nothing has left the pipeline as well.
	task automatic wait_quiet();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_pixels.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tga_rle_pkg::CFG_INDEX_W-1:0] idx,
		input logic [tga_rle_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		sb.write_reg(idx, data);
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_pixel_bytes(input int unsigned count);
		repeat (count) send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// One unit of random traffic. In compressed mode this is mostly a well-formed packet
	// with random content; some packets are cut short and some transactions are plain
	// noise. Small raw packets dominate so that headers come often.
	task automatic send_packet();
		int unsigned sz;
		int unsigned count;
		int unsigned len;
		logic [7:0]  hdr;
		sz = sb.pixel_size();
		if (!sb.rle_mode_cfg) begin
			send_pixel_bytes($urandom_range(1, 8) * sz);
		end else if ($urandom_range(0, 99) < 8) begin
			send_pixel_bytes($urandom_range(1, 6));
		end else begin
			if ($urandom_range(0, 1) == 1) begin
				hdr = 8'(128 + $urandom_range(0, 127));
				len = sz;
			end else begin
				count = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4) :
					$urandom_range(1, 128);
				hdr = 8'(count - 1);
				len = count * sz;
			end
			if ($urandom_range(0, 99) < 10)
				len = $urandom_range(0, len - 1);
			// A long packet is cut at the end of the phase so that the phase keeps to its
			// byte budget; the next phase carries on inside the open packet.
			if (len > PHASE_BYTES - phase_bytes - 1)
				len = PHASE_BYTES - phase_bytes - 1;
			send_byte(hdr, 1'b0);
			send_pixel_bytes(len);
		end
	endtask

	// Finishes the packet in progress so that the next byte is read as a header.
	task automatic reach_header();
		while (!sb.want_header)
			send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic compressed_setup();
		wait_quiet();
		write_reg(tga_rle_pkg::REG_COMPRESSED_MODE, 32'd1);
		write_reg(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'($urandom_range(3, 4)));
		end_writes();
		reach_header();
	endtask

	int unsigned idle_mix[4] = '{0, 76, 0, 14};
	int unsigned stall_mix[4] = '{0, 0, 76, 14};

	initial begin
		ending_t ending;
		int unsigned sz;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// The reset total of one pixel would end the image at once, so the total goes to
		// its maximum before any byte is sent.
		write_reg(tga_rle_pkg::REG_TOTAL_PIXELS, 32'hFFFF_FFFF);
		write_reg(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd4);
		write_reg(tga_rle_pkg::REG_COMPRESSED_MODE, 32'd1);
		end_writes();

		// Directed part. Smallest raw packet with an all-zero pixel, then the longest run
		// with an all-ones pixel.
		send_byte(8'h00, 1'b0);
		repeat (4) send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		repeat (4) send_byte(8'hFF, 1'b0);

		// The longest raw packet. Its first pixel is cut after three bytes and the size is
		// dropped to an out-of-range low value, so the fourth byte closes the pixel as a
		// three byte one with opaque alpha.
		send_byte(8'h7F, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h3C, 1'b0);
		wait_quiet();
		write_reg(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd0);
		end_writes();
		send_byte(8'hC3, 1'b0);

		// One byte into a three byte pixel, then an out-of-range high size that acts as four.
		send_byte(8'h81, 1'b0);
		wait_quiet();
		write_reg(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd7);
		end_writes();
		send_pixel_bytes(3);

		// Plain pixels with the raw packet still open, then back to compressed mode, which
		// resumes the packet where it was left.
		wait_quiet();
		write_reg(tga_rle_pkg::REG_COMPRESSED_MODE, 32'd0);
		write_reg(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd3);
		end_writes();
		send_pixel_bytes(3);
		wait_quiet();
		write_reg(tga_rle_pkg::REG_COMPRESSED_MODE, 32'd1);
		write_reg(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd4);
		end_writes();
		send_pixel_bytes(4);

		// Random part. Each phase has its own handshake pressure and register settings; the
		// first eight phases walk through every pixel size code.
		for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
			wait_quiet();
			idle_pct = idle_mix[p % 4];
			stall_pct = stall_mix[p % 4];
			write_reg(tga_rle_pkg::REG_BYTES_PER_PIXEL,
				(p < 8) ? 32'(p) : 32'($urandom_range(0, 7)));
			write_reg(tga_rle_pkg::REG_COMPRESSED_MODE,
				($urandom_range(0, 99) < 75) ? 32'd1 : 32'd0);
			write_reg(tga_rle_pkg::REG_TOTAL_PIXELS, (p % 3 == 0) ? 32'hFFFF_FFFF :
				sb.pixels_out + 32'd1_000_000 + 32'($urandom_range(0, 1_000_000)));
			end_writes();
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES)
				send_packet();
		end

		// The one ending of this run. The core stops for good afterwards.
		ending = ending_t'($urandom_range(0, 5));
		case (ending)
			END_HEADER_EOS: begin
				compressed_setup();
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			END_PIXEL_EOS: begin
				wait_quiet();
				write_reg(tga_rle_pkg::REG_COMPRESSED_MODE, 32'd0);
				end_writes();
				while (sb.byte_pos != 2'd0)
					send_byte(8'($urandom_range(0, 255)), 1'b0);
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			END_RAW_EOS, END_BOUNDARY_EOS: begin
				compressed_setup();
				sz = sb.pixel_size();
				// A raw packet with pixels still to come flags its last pixel as truncated;
				// a packet that ends with the stream does not.
				if (ending == END_RAW_EOS)
					send_byte(8'($urandom_range(1, 127)), 1'b0);
				else if ($urandom_range(0, 1) == 1)
					send_byte(8'h00, 1'b0);
				else
					send_byte(8'($urandom_range(128, 255)), 1'b0);
				send_pixel_bytes(sz - 1);
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			END_RUN_CLAMP: begin
				compressed_setup();
				wait_quiet();
				write_reg(tga_rle_pkg::REG_TOTAL_PIXELS,
					sb.pixels_out + 32'($urandom_range(1, 3)));
				end_writes();
				send_byte(8'hFF, 1'b0);
				send_pixel_bytes(sb.pixel_size());
			end
			default: begin
				wait_quiet();
				write_reg(tga_rle_pkg::REG_TOTAL_PIXELS,
					($urandom_range(0, 1) == 1) ? 32'd0 : sb.pixels_out);
				end_writes();
				send_byte(8'($urandom_range(0, 255)), 1'b0);
			end
		endcase

		// Bytes after the end must be dropped without any output.
		repeat (6) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_pixels.size() != 0) begin
			$error("%0d predicted pixels never arrived", sb.expected_pixels.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
